[sv/fls_pkg.sv]
// Package for the free-list slot table: sizes, action and status codes, state type.
package fls_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int LINK_W  = $clog2(TABLE_DEPTH + 1);
  localparam int STORE_W = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;
  localparam logic [1:0] ACT_WRITE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fls_state_t;

endpackage

[sv/free_list_slot_table_unit.sv]
// Top level of the free-list slot table: request decode, free list and result register.
//
// Each item is accepted and then executed: the accept cycle issues the reads
// of the link and payload memories, and the execute state that follows, once
// their registered data is back, decides the result, writes back and updates
// the free-list head. The link memory starts out as slot i linking to slot
// i + 1 through one valid flag per slot that reset clears, so there is no
// clearing pass and items are taken as soon as reset is released. A new item
// is accepted while a result waits on the output; it then holds in the
// execute state until the result register is free.
module free_list_slot_table_unit
  import fls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  slot_index,
  input  logic [31:0] payload_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  slot_out,
  output logic [31:0] payload_out
);

  fls_state_t state, state_next;

  logic [LINK_W-1:0]  head;
  logic [LINK_W-1:0]  head_next;
  logic [TABLE_DEPTH-1:0] in_use;
  logic [TABLE_DEPTH-1:0] link_valid;

  logic [1:0]   req_act;
  logic [7:0]   req_idx;
  logic [31:0]  req_data;

  logic [LINK_W-1:0]  link_rdata;
  logic [STORE_W-1:0] pay_rdata;

  logic               in_accept;
  logic               exec_go;
  logic [ADDR_W-1:0]  head_addr;
  logic [ADDR_W-1:0]  req_addr;
  logic [LINK_W-1:0]  link_eff;
  logic               range_err;
  logic [1:0]         res_status;
  logic [7:0]         res_slot;
  logic [31:0]        res_payload;
  logic               set_use;
  logic               clr_use;
  logic               link_we;
  logic               pay_we;

  assign in_accept = in_valid && in_ready;
  assign exec_go   = (state == S_EXEC) && (!out_valid || out_ready);
  assign head_addr = head[ADDR_W-1:0];
  assign req_addr  = req_idx[ADDR_W-1:0];
  assign range_err = (32'(req_idx) >= 32'(TABLE_DEPTH));
  assign link_eff  = link_valid[head_addr] ? link_rdata : head + LINK_W'(1);

  fls_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(LINK_W)
  ) u_link_ram (
    .clk  (clk),
    .we   (exec_go && link_we),
    .waddr(req_addr),
    .wdata(head),
    .re   (in_accept),
    .raddr(head_addr),
    .rdata(link_rdata)
  );

  fls_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(STORE_W)
  ) u_payload_ram (
    .clk  (clk),
    .we   (exec_go && pay_we),
    .waddr(req_addr),
    .wdata(req_data[STORE_W-1:0]),
    .re   (in_accept),
    .raddr(slot_index[ADDR_W-1:0]),
    .rdata(pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_status  = ST_OK;
    res_slot    = 8'd0;
    res_payload = 32'd0;
    head_next   = head;
    set_use     = 1'b0;
    clr_use     = 1'b0;
    link_we     = 1'b0;
    pay_we      = 1'b0;
    if (req_act == ACT_ALLOC) begin
      if (32'(head) >= 32'(TABLE_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        res_slot  = 8'(head);
        set_use   = 1'b1;
        head_next = link_eff;
      end
    end else if (range_err) begin
      res_status = ST_RANGE;
    end else if (!in_use[req_addr]) begin
      res_status = ST_FREE;
    end else begin
      case (req_act)
        ACT_RELEASE: begin
          link_we   = 1'b1;
          clr_use   = 1'b1;
          head_next = LINK_W'(req_idx);
        end
        ACT_READ: begin
          res_payload = 32'(pay_rdata);
        end
        ACT_WRITE: begin
          pay_we = 1'b1;
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_act  <= action;
      req_idx  <= slot_index;
      req_data <= payload_in;
    end
    if (exec_go) begin
      status      <= res_status;
      slot_out    <= res_slot;
      payload_out <= res_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      head       <= '0;
      in_use     <= '0;
      link_valid <= '0;
    end else begin
      if (exec_go) begin
        out_valid <= 1'b1;
        head      <= head_next;
        if (set_use) begin
          in_use[head_addr] <= 1'b1;
        end
        if (clr_use) begin
          in_use[req_addr] <= 1'b0;
        end
        if (link_we) begin
          link_valid[req_addr] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_exec_loads_result: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> out_valid)
    else $error("result register not loaded after execute");

  a_full_means_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (32'(head) == 32'(TABLE_DEPTH)))
    else $error("table full reported with a non-empty free list");

  a_alloc_marks_used: assert property (@(posedge clk) disable iff (rst)
    (exec_go && req_act == ACT_ALLOC && res_status == ST_OK)
    |=> in_use[$past(head_addr)])
    else $error("allocated slot not marked in use");

  a_release_pushes: assert property (@(posedge clk) disable iff (rst)
    (exec_go && req_act == ACT_RELEASE && res_status == ST_OK)
    |=> (head == LINK_W'($past(req_idx)) && !in_use[$past(req_addr)]))
    else $error("released slot not pushed onto the free list");
`endif

endmodule

[sv/fls_ram.sv]
// Simple dual-port RAM with registered read data, one write and one read port.
module fls_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
